/* sv/tsbq_pkg.sv */
// ============================================================================
// tsbq_pkg: shared types and constants of the time sorted batch queue
// Entry layout, result codes and interval helpers used by the queue, checker and bench.
// ============================================================================
package tsbq_pkg;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // File type codes.
  localparam logic [1:0] TYPE_UPDATES = 2'd0;
  localparam logic [1:0] TYPE_RIBS    = 2'd1;

  // Result kinds.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_BATCH  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Insert status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // One stored queue entry.
  typedef struct packed {
    logic [1:0]  ftype;
    logic [3:0]  project;
    logic [7:0]  collector;
    logic [15:0] handle;
    logic [23:0] span;
    logic [30:0] ftime;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Interval bounds, wide enough that they never wrap.
  typedef logic signed [32:0] bound_t;

  function automatic bound_t iv_lo(input entry_t e);
    bound_t r;
    r = '0;
    if (e.ftype == TYPE_RIBS) begin
      r = $signed({2'b00, e.ftime}) - $signed({9'b0, e.span});
    end else if (e.ftype == TYPE_UPDATES) begin
      r = $signed({2'b00, e.ftime});
    end
    return r;
  endfunction

  function automatic bound_t iv_hi(input entry_t e);
    bound_t r;
    r = '0;
    if (e.ftype == TYPE_RIBS || e.ftype == TYPE_UPDATES) begin
      r = $signed({2'b00, e.ftime}) + $signed({9'b0, e.span});
    end
    return r;
  endfunction

endpackage

/* sv/tsbq_ram.sv */
// ============================================================================
// tsbq_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ============================================================================
module tsbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/time_sorted_batch_queue_unit.sv */
// ============================================================================
// time_sorted_batch_queue_unit: time sorted file queue with batch pop
// Sorted insert with duplicate and full checks; pop of an overlapping run.
// ============================================================================
// Entries live in one RAM used as a ring from a head pointer, and a small
// sequencer walks it one entry at a time, reading each entry and then
// checking it. An insert scans for its slot and then moves the entries
// behind it up one slot each; a pop only advances the head and moves no
// entries. Each request is accepted when start is high and busy is low,
// and busy falls in the cycle that shows its last result; a pop of an
// empty queue answers in the next cycle without raising busy. Results
// appear for one cycle each with out_valid; the receiver cannot stall
// them, and out_last marks the final result of a request.
module time_sorted_batch_queue_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_BATCH   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_file_handle,
  input  logic [30:0] in_file_time,
  input  logic [23:0] in_time_span,
  input  logic [7:0]  in_collector_id,
  input  logic [3:0]  in_project_id,
  input  logic [1:0]  in_file_type,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_handle,
  output logic [30:0] out_time,
  output logic [23:0] out_span,
  output logic [7:0]  out_collector,
  output logic [3:0]  out_project,
  output logic [1:0]  out_type,
  output logic        out_last
);
  import tsbq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_CK = 4'd2;
  localparam logic [3:0] S_DECIDE  = 4'd3;
  localparam logic [3:0] S_SH_RD   = 4'd4;
  localparam logic [3:0] S_SH_WR   = 4'd5;
  localparam logic [3:0] S_INS_WR  = 4'd6;
  localparam logic [3:0] S_POP_RD  = 4'd7;
  localparam logic [3:0] S_POP_CK  = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] j_r, j_nxt;
  bound_t        reach_r, reach_nxt;
  entry_t        req_r, req_nxt;
  entry_t        pend_r, pend_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic [1:0]    ostat_r, ostat_nxt;
  entry_t        oent_r, oent_nxt;
  logic          olast_r, olast_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  // Ring address of a logical queue position.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(i);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  tsbq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port control.
  always_comb begin
    ram_raddr = phys(head_r, idx_r);
    if (state_r == S_SH_RD) begin
      ram_raddr = phys(head_r, j_r - CW'(1));
    end
    ram_we    = 1'b0;
    ram_waddr = phys(head_r, idx_r);
    ram_wdata = req_r;
    if (state_r == S_SH_WR) begin
      ram_we    = 1'b1;
      ram_waddr = phys(head_r, j_r);
      ram_wdata = ram_rdata;
    end else if (state_r == S_INS_WR) begin
      ram_we = 1'b1;
    end
  end

  // Sequencer and result generation.
  always_comb begin
    bound_t lo, hi, rc;
    logic   pop_done;

    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    reach_nxt = reach_r;
    req_nxt   = req_r;
    pend_nxt  = pend_r;
    ov_nxt    = 1'b0;
    okind_nxt = KIND_INSERT;
    ostat_nxt = ST_INSERTED;
    oent_nxt  = '0;
    olast_nxt = 1'b0;
    pop_done  = 1'b0;
    lo = iv_lo(ram_rdata);
    hi = iv_hi(ram_rdata);
    rc = (idx_r == '0) ? hi : reach_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt.ftype     = in_file_type;
          req_nxt.project   = in_project_id;
          req_nxt.collector = in_collector_id;
          req_nxt.handle    = in_file_handle;
          req_nxt.span      = in_time_span;
          req_nxt.ftime     = in_file_time;
          idx_nxt = '0;
          if (in_command == CMD_INSERT) begin
            state_nxt = S_SCAN_RD;
          end else if (count_r == '0) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_EMPTY;
            olast_nxt = 1'b1;
          end else begin
            state_nxt = S_POP_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = (idx_r == count_r) ? S_DECIDE : S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (ram_rdata.ftime > req_r.ftime) begin
          state_nxt = S_DECIDE;
        end else if (ram_rdata.ftime == req_r.ftime &&
                     {ram_rdata.ftype, ram_rdata.project, ram_rdata.collector} ==
                     {req_r.ftype, req_r.project, req_r.collector}) begin
          ov_nxt    = 1'b1;
          ostat_nxt = ST_DUP;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (ram_rdata.ftime == req_r.ftime && req_r.ftype == TYPE_RIBS &&
                     ram_rdata.ftype == TYPE_UPDATES) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (count_r == CW'(QUEUE_DEPTH)) begin
          ov_nxt    = 1'b1;
          ostat_nxt = ST_FULL;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (idx_r == count_r) begin
          state_nxt = S_INS_WR;
        end else begin
          j_nxt     = count_r;
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        j_nxt     = j_r - CW'(1);
        state_nxt = (j_r - CW'(1) == idx_r) ? S_INS_WR : S_SH_RD;
      end
      S_INS_WR: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_IDLE;
      end
      S_POP_RD: begin
        if (idx_r == count_r || 32'(idx_r) >= MAX_BATCH) begin
          pop_done = 1'b1;
        end else begin
          state_nxt = S_POP_CK;
        end
      end
      S_POP_CK: begin
        if (lo >= rc) begin
          pop_done = 1'b1;
        end else begin
          // The previous entry is now known not to be the last one.
          if (idx_r != '0) begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_BATCH;
            oent_nxt  = pend_r;
          end
          pend_nxt  = ram_rdata;
          reach_nxt = (hi > rc) ? hi : rc;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_POP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of a pop: emit the held entry as last, or an empty batch.
    if (pop_done) begin
      ov_nxt    = 1'b1;
      olast_nxt = 1'b1;
      state_nxt = S_IDLE;
      if (idx_r == '0) begin
        okind_nxt = KIND_EMPTY;
      end else begin
        okind_nxt = KIND_BATCH;
        oent_nxt  = pend_r;
        head_nxt  = phys(head_r, idx_r);
        count_nxt = count_r - idx_r;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    reach_r <= reach_nxt;
    req_r   <= req_nxt;
    pend_r  <= pend_nxt;
    okind_r <= okind_nxt;
    ostat_r <= ostat_nxt;
    oent_r  <= oent_nxt;
    olast_r <= olast_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_kind      = okind_r;
  assign out_status    = ostat_r;
  assign out_handle    = oent_r.handle;
  assign out_time      = oent_r.ftime;
  assign out_span      = oent_r.span;
  assign out_collector = oent_r.collector;
  assign out_project   = oent_r.project;
  assign out_type      = oent_r.ftype;
  assign out_last      = olast_r;

endmodule

/* sv/tsbq_checker.sv */
// ============================================================================
// tsbq_checker: port level checks of the batch queue
// Watches the request and result ports and flags sequencing errors.
// ============================================================================
module tsbq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic [1:0] out_status,
  input logic       out_last
);
  import tsbq_pkg::*;

  // An accepted request either occupies the unit or answers in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request neither started nor answered");

  // Insert status and empty batch results are single results.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BATCH |-> out_last)
    else $error("single result without last");

  // An insert status is one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_INSERT |->
      (out_status == ST_INSERTED || out_status == ST_DUP || out_status == ST_FULL))
    else $error("bad insert status");

  // A result that is not the last one appears only while the unit is busy.
  a_busy_before_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-last result while idle");

endmodule

bind time_sorted_batch_queue_unit tsbq_checker u_tsbq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_kind   (out_kind),
  .out_status (out_status),
  .out_last   (out_last)
);

/* tb/time_sorted_batch_queue_unit_tb.sv */
// ----------------------------------------------------------------------------
// time_sorted_batch_queue_unit_tb: self-checking bench of the sorted queue
// A directed table followed by random inserts and pops; every result is
// checked against a typed row or a predictor with its own queue copy.
// ----------------------------------------------------------------------------
module time_sorted_batch_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsbq_pkg::*;

  localparam int DEPTH     = 64;
  localparam int BATCH_MAX = 64;
  localparam int SETTLE    = 400;

  // One result as seen on the output ports.
  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] handle;
    logic [30:0] ftime;
    logic [23:0] span;
    logic [7:0]  collector;
    logic [3:0]  project;
    logic [1:0]  ftype;
    logic        last;
  } result_t;

  // One request; a typed row carries its result kind and status.
  typedef struct {
    logic        cmd;
    logic [15:0] handle;
    logic [30:0] ftime;
    logic [23:0] span;
    logic [7:0]  collector;
    logic [3:0]  project;
    logic [1:0]  ftype;
    bit          typed;
    logic [1:0]  tkind;
    logic [1:0]  tstatus;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [15:0] in_file_handle;
  logic [30:0] in_file_time;
  logic [23:0] in_time_span;
  logic [7:0]  in_collector_id;
  logic [3:0]  in_project_id;
  logic [1:0]  in_file_type;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [1:0]  out_status;
  logic [15:0] out_handle;
  logic [30:0] out_time;
  logic [23:0] out_span;
  logic [7:0]  out_collector;
  logic [3:0]  out_project;
  logic [1:0]  out_type;
  logic        out_last;

  // Predictor state: the queue contents in sorted order.
  entry_t  queue_slots[DEPTH];
  int      queue_count;
  result_t pending_results[$];
  request_t directed_rows[$];
  int      error_count;
  int      burst_left;

  time_sorted_batch_queue_unit #(
    .QUEUE_DEPTH(DEPTH),
    .MAX_BATCH  (BATCH_MAX)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_file_handle (in_file_handle),
    .in_file_time   (in_file_time),
    .in_time_span   (in_time_span),
    .in_collector_id(in_collector_id),
    .in_project_id  (in_project_id),
    .in_file_type   (in_file_type),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_handle     (out_handle),
    .out_time       (out_time),
    .out_span       (out_span),
    .out_collector  (out_collector),
    .out_project    (out_project),
    .out_type       (out_type),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Interval of a stored entry; other types have the empty interval.
  function automatic void entry_interval(input entry_t e, output longint lo,
                                         output longint hi);
    lo = 0;
    hi = 0;
    if (e.ftype == TYPE_RIBS) begin
      lo = longint'(e.ftime) - longint'(e.span);
      hi = longint'(e.ftime) + longint'(e.span);
    end else if (e.ftype == TYPE_UPDATES) begin
      lo = longint'(e.ftime);
      hi = longint'(e.ftime) + longint'(e.span);
    end
  endfunction

  function automatic result_t status_result(input logic [1:0] kind,
                                            input logic [1:0] status);
    result_t r;
    r        = '{default: '0};
    r.kind   = kind;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

  // Sorted insert with duplicate and full checks.
  function automatic result_t predict_insert(input request_t rq);
    int  pos;
    bit  stop;
    bit  dup;
    entry_t e;
    pos  = 0;
    stop = 0;
    dup  = 0;
    while (!stop && pos < queue_count && queue_slots[pos].ftime <= rq.ftime) begin
      if (queue_slots[pos].ftime == rq.ftime) begin
        if (queue_slots[pos].ftype == rq.ftype && queue_slots[pos].project == rq.project
            && queue_slots[pos].collector == rq.collector) begin
          dup  = 1;
          stop = 1;
        end else if (rq.ftype == TYPE_RIBS && queue_slots[pos].ftype == TYPE_UPDATES) begin
          stop = 1;
        end
      end
      if (!stop) pos++;
    end
    if (dup) return status_result(KIND_INSERT, ST_DUP);
    if (queue_count >= DEPTH) return status_result(KIND_INSERT, ST_FULL);
    for (int j = queue_count; j > pos; j--) queue_slots[j] = queue_slots[j-1];
    e.ftime     = rq.ftime;
    e.span      = rq.span;
    e.handle    = rq.handle;
    e.collector = rq.collector;
    e.project   = rq.project;
    e.ftype     = rq.ftype;
    queue_slots[pos] = e;
    queue_count++;
    return status_result(KIND_INSERT, ST_INSERTED);
  endfunction

  // Pop of the leading chain of overlapping intervals.
  task automatic predict_pop(output result_t res[$]);
    int     n;
    longint lo;
    longint hi;
    longint reach;
    result_t r;
    res = {};
    if (queue_count == 0) begin
      res.push_back(status_result(KIND_EMPTY, ST_INSERTED));
      return;
    end
    entry_interval(queue_slots[0], lo, reach);
    n = 0;
    while (n < queue_count && n < BATCH_MAX) begin
      entry_interval(queue_slots[n], lo, hi);
      if (lo >= reach) break;
      if (hi > reach) reach = hi;
      n++;
    end
    if (n == 0) begin
      res.push_back(status_result(KIND_EMPTY, ST_INSERTED));
      return;
    end
    for (int j = 0; j < n; j++) begin
      r.kind      = KIND_BATCH;
      r.status    = ST_INSERTED;
      r.handle    = queue_slots[j].handle;
      r.ftime     = queue_slots[j].ftime;
      r.span      = queue_slots[j].span;
      r.collector = queue_slots[j].collector;
      r.project   = queue_slots[j].project;
      r.ftype     = queue_slots[j].ftype;
      r.last      = (j == n - 1);
      res.push_back(r);
    end
    for (int j = n; j < queue_count; j++) queue_slots[j-n] = queue_slots[j];
    queue_count -= n;
  endtask

  // Drive one request, wait for it to be taken and record its results.
  task automatic send_request(input request_t rq);
    int      gap;
    result_t res[$];
    result_t r;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= rq.cmd;
    in_file_handle  <= rq.handle;
    in_file_time    <= rq.ftime;
    in_time_span    <= rq.span;
    in_collector_id <= rq.collector;
    in_project_id   <= rq.project;
    in_file_type    <= rq.ftype;
    do @(posedge clk); while (busy);
    if (rq.cmd == CMD_INSERT) begin
      r = predict_insert(rq);
      res.push_back(r);
    end else begin
      predict_pop(res);
    end
    if (rq.typed) begin
      res = {};
      res.push_back(status_result(rq.tkind, rq.tstatus));
    end
    foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic request_t make_request(input logic cmd, input logic [15:0] h,
                                            input logic [30:0] t, input logic [23:0] s,
                                            input logic [7:0] c, input logic [3:0] p,
                                            input logic [1:0] ty);
    request_t rq;
    rq = '{cmd: cmd, handle: h, ftime: t, span: s, collector: c, project: p,
           ftype: ty, typed: 0, tkind: KIND_INSERT, tstatus: ST_INSERTED};
    return rq;
  endfunction

  function automatic void add_row(input request_t rq);
    directed_rows.push_back(rq);
  endfunction

  function automatic void add_typed(input request_t rq, input logic [1:0] k,
                                    input logic [1:0] st);
    rq.typed   = 1;
    rq.tkind   = k;
    rq.tstatus = st;
    directed_rows.push_back(rq);
  endfunction

  // Random request: narrow time window so collisions and overlaps happen.
  function automatic request_t random_request(input int insert_weight);
    request_t rq;
    rq = make_request(CMD_INSERT, 16'($urandom), 31'(1000 + $urandom_range(0, 127)),
                      24'($urandom_range(0, 40)), 8'($urandom_range(0, 3)),
                      4'($urandom_range(0, 2)), 2'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) >= insert_weight) rq.cmd = CMD_POP;
    if ($urandom_range(0, 9) == 0) rq.ftime = 31'($urandom);
    if ($urandom_range(0, 9) == 0) rq.ftime = 31'($urandom_range(0, 60));
    if ($urandom_range(0, 7) == 0) rq.span = 24'($urandom);
    if ($urandom_range(0, 9) == 0) rq.span = '0;
    if ($urandom_range(0, 5) == 0) rq.collector = 8'($urandom);
    if ($urandom_range(0, 5) == 0) rq.project = 4'($urandom);
    if ($urandom_range(0, 9) == 0) rq.ftype = 2'($urandom_range(2, 3));
    return rq;
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is a result.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d", out_kind);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind);
          error_count++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          error_count++;
        end
        if (out_handle !== e.handle) begin
          $error("handle: expected %0h, got %0h", e.handle, out_handle);
          error_count++;
        end
        if (out_time !== e.ftime) begin
          $error("time: expected %0d, got %0d", e.ftime, out_time);
          error_count++;
        end
        if (out_span !== e.span) begin
          $error("span: expected %0d, got %0d", e.span, out_span);
          error_count++;
        end
        if (out_collector !== e.collector) begin
          $error("collector: expected %0d, got %0d", e.collector, out_collector);
          error_count++;
        end
        if (out_project !== e.project) begin
          $error("project: expected %0d, got %0d", e.project, out_project);
          error_count++;
        end
        if (out_type !== e.ftype) begin
          $error("type: expected %0d, got %0d", e.ftype, out_type);
          error_count++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Overall run limit.
  initial begin
    #20ms;
    $display("time_sorted_batch_queue_unit regression: fail");
    $finish;
  end

  initial begin
    start           = 1'b0;
    rst_n           = 1'b0;
    in_command      = CMD_INSERT;
    in_file_handle  = '0;
    in_file_time    = '0;
    in_time_span    = '0;
    in_collector_id = '0;
    in_project_id   = '0;
    in_file_type    = TYPE_UPDATES;
    error_count     = 0;
    queue_count     = 0;
    burst_left      = 0;

    // Directed table: empty pop, duplicates, ribs priority, extremes.
    add_typed(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES), KIND_EMPTY, ST_INSERTED);
    add_typed(make_request(CMD_INSERT, 16'hFFFF, 100, 50, 1, 1, TYPE_UPDATES),
              KIND_INSERT, ST_INSERTED);
    add_typed(make_request(CMD_INSERT, 16'h1234, 100, 7, 1, 1, TYPE_UPDATES),
              KIND_INSERT, ST_DUP);
    add_row(make_request(CMD_INSERT, 16'h0001, 100, 10, 1, 1, TYPE_RIBS));
    add_row(make_request(CMD_INSERT, 16'h0002, 100, 24'hFFFFFF, 1, 1, 2'd2));
    add_row(make_request(CMD_INSERT, 16'h0003, 100, 5, 1, 1, 2'd3));
    add_typed(make_request(CMD_INSERT, 16'h0004, 100, 5, 1, 1, 2'd3), KIND_INSERT, ST_DUP);
    add_row(make_request(CMD_INSERT, 16'h0005, 100, 3, 255, 15, TYPE_UPDATES));
    add_row(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES));
    // An empty-interval head blocks the pop until a ribs entry goes in front.
    add_row(make_request(CMD_INSERT, 16'h0006, 0, 0, 2, 3, TYPE_UPDATES));
    add_typed(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES), KIND_EMPTY, ST_INSERTED);
    add_row(make_request(CMD_INSERT, 16'h0007, 0, 5, 3, 3, TYPE_RIBS));
    add_row(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES));
    add_row(make_request(CMD_INSERT, 16'h8000, 31'h7FFFFFFF, 24'hFFFFFF, 255, 15,
                         TYPE_RIBS));
    add_row(make_request(CMD_INSERT, 16'h0000, 31'h7FFFFFFF, 24'hFFFFFF, 255, 15,
                         TYPE_UPDATES));
    add_row(make_request(CMD_INSERT, 16'h5555, 31'h7FFFFFF0, 1, 0, 0, TYPE_UPDATES));
    add_row(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES));
    add_row(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES));
    add_row(make_request(CMD_POP, 0, 0, 0, 0, 0, TYPE_UPDATES));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Hold off until the queue has answered everything sent so far.
    wait_drained();

    // Fill the queue to capacity and beyond, then pop from it.
    for (int i = 0; i < 75; i++) send_request(random_request(100));
    for (int i = 0; i < 20; i++) send_request(random_request(0));
    wait_drained();

    // Mixed random traffic.
    for (int i = 0; i < 170; i++) send_request(random_request(65));

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0) begin
      $display("time_sorted_batch_queue_unit regression: pass");
    end else begin
      $display("time_sorted_batch_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
